// ===== hw/rtl/kcg_pkg.sv =====
// Shared types and constants for the key click gesture classifier.
// Holds the counter width, phase and event codes, and the register index map.
// No dependencies.
`default_nettype none

package kcg_pkg;

   // Width of the press and release counters
   localparam int COUNT_WIDTH = 16;
   // Width of the timing limit registers
   localparam int LIMIT_WIDTH = 16;
   // Configuration port widths
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   // Compare width wide enough for either operand
   localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESS_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_TICKS    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE_TICKS = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOWN_LEVEL    = 2'd3;

   // Reset values of the configuration registers
   localparam logic [LIMIT_WIDTH-1:0] PRESS_TICKS_RESET   = 16'd2;
   localparam logic [LIMIT_WIDTH-1:0] LONG_TICKS_RESET    = 16'd100;
   localparam logic [LIMIT_WIDTH-1:0] RELEASE_TICKS_RESET = 16'd30;
   localparam logic                   DOWN_LEVEL_RESET    = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_FIRST     = 3'd1,
      PH_GAP       = 3'd2,
      PH_SECOND    = 3'd3,
      PH_DBL_WAIT  = 3'd4,
      PH_LONG_WAIT = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_CLICK  = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   // Gesture state carried from one tick to the next
   typedef struct packed {
      phase_type              phase;
      logic [COUNT_WIDTH-1:0] down_count;
      logic [COUNT_WIDTH-1:0] up_count;
   } gesture_state_type;

   // Timing limits and polarity
   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] press_ticks;
      logic [LIMIT_WIDTH-1:0] long_ticks;
      logic [LIMIT_WIDTH-1:0] release_ticks;
      logic                   down_level;
   } gesture_cfg_type;

endpackage : kcg_pkg

`default_nettype wire

// ===== hw/rtl/kcg_step.sv =====
// Next-state logic of the gesture machine for one scan tick.
// Purely combinational; depends on kcg_pkg.
`default_nettype none

module kcg_step
   import kcg_pkg::*;
(
   input  wire gesture_state_type cur_state,
   input  wire gesture_cfg_type   cfg,
   input  wire logic              key_level,
   output gesture_state_type      nxt_state,
   output event_type              event_code
);

   logic                   down;
   logic [COUNT_WIDTH-1:0] down_inc;
   logic [COUNT_WIDTH-1:0] up_inc;
   logic                   down_ge_press;
   logic                   down_ge_long;
   logic                   up_ge_release;

   // Saturating increments and limit compares
   always_comb begin
      down     = (key_level == cfg.down_level);
      down_inc = (&cur_state.down_count) ? cur_state.down_count
                                         : cur_state.down_count + 1'b1;
      up_inc   = (&cur_state.up_count) ? cur_state.up_count
                                       : cur_state.up_count + 1'b1;
      down_ge_press = CMP_WIDTH'(down_inc) >= CMP_WIDTH'(cfg.press_ticks);
      down_ge_long  = CMP_WIDTH'(down_inc) >= CMP_WIDTH'(cfg.long_ticks);
      up_ge_release = CMP_WIDTH'(up_inc)   >= CMP_WIDTH'(cfg.release_ticks);
   end

   // Phase transitions
   always_comb begin
      nxt_state  = cur_state;
      event_code = EV_NONE;
      case (cur_state.phase)
         PH_IDLE: begin
            if (down) begin
               nxt_state.down_count = down_inc;
               if (down_ge_press) nxt_state.phase = PH_FIRST;
            end else begin
               nxt_state.down_count = '0;
            end
         end
         PH_FIRST: begin
            if (down) begin
               nxt_state.down_count = down_inc;
               if (down_ge_long) begin
                  nxt_state.down_count = '0;
                  event_code           = EV_LONG;
                  nxt_state.phase      = PH_LONG_WAIT;
               end
            end else begin
               nxt_state.down_count = '0;
               nxt_state.phase      = PH_GAP;
            end
         end
         PH_GAP: begin
            if (!down) begin
               nxt_state.up_count = up_inc;
               if (up_ge_release) begin
                  nxt_state.up_count = '0;
                  event_code         = EV_CLICK;
                  nxt_state.phase    = PH_IDLE;
               end
            end else begin
               nxt_state.down_count = '0;
               nxt_state.phase      = PH_SECOND;
            end
         end
         PH_SECOND: begin
            if (down) begin
               nxt_state.down_count = down_inc;
               if (down_ge_press) begin
                  nxt_state.down_count = '0;
                  nxt_state.phase      = PH_DBL_WAIT;
               end
            end else begin
               // release count resumes after a short second press; it holds while the key is down
               nxt_state.down_count = '0;
               nxt_state.up_count   = up_inc;
               if (up_ge_release) begin
                  nxt_state.up_count = '0;
                  event_code         = EV_CLICK;
                  nxt_state.phase    = PH_IDLE;
               end
            end
         end
         PH_DBL_WAIT: begin
            if (!down) begin
               event_code      = EV_DOUBLE;
               nxt_state.phase = PH_IDLE;
            end
         end
         PH_LONG_WAIT: begin
            if (!down) nxt_state.phase = PH_IDLE;
         end
         default: begin
            nxt_state.phase = PH_IDLE;
         end
      endcase
   end

endmodule : kcg_step

`default_nettype wire

// ===== hw/rtl/key_click_gesture_classifier.sv =====
// Key click gesture classifier: rsp_valid rises in the cycle after an item is accepted,
// taking 1 item per cycle unless a held result stalls it; the output register frees as it is taken.
// Synchronous active-high reset returns the phase to idle, clears both counters
// and loads press_ticks=2, long_ticks=100, release_ticks=30, down_level=1.
// Uses kcg_pkg and kcg_step.
`default_nettype none

module key_click_gesture_classifier
   import kcg_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // scan tick input
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_key_level,
   // gesture result
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_event_code,
   output logic [2:0]                      rsp_phase_now,
   // configuration writes
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   gesture_cfg_type   cfg_ff;
   gesture_state_type state_ff;
   gesture_state_type state_in;
   event_type         event_in;
   logic              rsp_valid_ff;
   logic [1:0]        event_ff;
   logic [2:0]        phase_out_ff;
   logic              req_take;

   // Output register is free when empty or being drained this cycle
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_ticks   <= PRESS_TICKS_RESET;
         cfg_ff.long_ticks    <= LONG_TICKS_RESET;
         cfg_ff.release_ticks <= RELEASE_TICKS_RESET;
         cfg_ff.down_level    <= DOWN_LEVEL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PRESS_TICKS:   cfg_ff.press_ticks   <= LIMIT_WIDTH'(csr_data);
            CSR_LONG_TICKS:    cfg_ff.long_ticks    <= LIMIT_WIDTH'(csr_data);
            CSR_RELEASE_TICKS: cfg_ff.release_ticks <= LIMIT_WIDTH'(csr_data);
            CSR_DOWN_LEVEL:    cfg_ff.down_level    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Per-tick gesture update
   kcg_step u_step (
      .cur_state  (state_ff),
      .cfg        (cfg_ff),
      .key_level  (req_key_level),
      .nxt_state  (state_in),
      .event_code (event_in)
   );

   // Gesture state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_IDLE;
         state_ff.down_count <= '0;
         state_ff.up_count   <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         event_ff     <= event_in;
         phase_out_ff <= state_in.phase;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = event_ff;
   assign rsp_phase_now  = phase_out_ff;

`ifndef SYNTH
   // A double click always ends in idle
   a_double_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_code == EV_DOUBLE) |-> (rsp_phase_now == PH_IDLE))
      else $error("double click result without return to idle");

   // A long press always waits for release
   a_long_to_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_code == EV_LONG) |-> (rsp_phase_now == PH_LONG_WAIT))
      else $error("long press result not followed by long wait phase");

   // Reported phase tracks the state register
   a_phase_match: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (rsp_phase_now == state_ff.phase))
      else $error("reported phase differs from state");

   // State only moves when an item is taken
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!req_take && !$past(reset)) |=> $stable(state_ff))
      else $error("gesture state changed without an item");
`endif

endmodule : key_click_gesture_classifier

`default_nettype wire
